// ===== rtl/core/cchp_pkg.sv =====
// Shared types and constants for the core-count hotplug policy block.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps
`default_nettype none

package cchp_pkg;

	// Fixed-point format of the load sample
	localparam int LoadFracBits = 11;
	localparam int LoadW        = 16;

	// Threshold compare: thresholds are small integers scaled by a shift
	localparam int ThrW       = 5;
	localparam int CmpW       = (ThrW + LoadFracBits > LoadW) ? ThrW + LoadFracBits : LoadW;
	localparam int FullShift  = LoadFracBits - 3;
	localparam int EcoShift   = LoadFracBits - 1;
	localparam int FullLevels = 3;

	localparam logic [ThrW-1:0] FullThr [FullLevels] = '{5'd5, 5'd7, 5'd9};
	localparam logic [ThrW-1:0] EcoThr   = 5'd3;
	localparam logic [ThrW-1:0] FullHyst = 5'd8;
	localparam logic [ThrW-1:0] EcoHyst  = 5'd4;

	// Field widths
	localparam int ReqW     = 2;
	localparam int MaskW    = 4;
	localparam int TgtW     = 3;
	localparam int PersistW = 6;

	// Persistence reloads
	localparam logic [PersistW-1:0] PersistDual = 6'd50;
	localparam logic [PersistW-1:0] PersistTri  = 6'd40;
	localparam logic [PersistW-1:0] PersistQuad = 6'd30;

	// Request codes
	localparam logic [ReqW-1:0] ReqTick    = 2'd0;
	localparam logic [ReqW-1:0] ReqSuspend = 2'd1;
	localparam logic [ReqW-1:0] ReqResume  = 2'd2;

	// Configuration register indexes
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 1;
	localparam logic [CfgIdxW-1:0] CfgEnable = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgEco    = 1'd1;

	typedef struct packed {
		logic enable;
		logic eco_mode;
	} cchp_cfg_t;

	typedef struct packed {
		logic [TgtW-1:0]     last_target;
		logic [PersistW-1:0] persist_left;
		logic                is_suspended;
	} cchp_state_t;

	typedef struct packed {
		logic [ReqW-1:0]  req_type;
		logic [LoadW-1:0] load_sample;
		logic [MaskW-1:0] online_mask;
	} cchp_req_t;

	typedef struct packed {
		logic [MaskW-1:0] up_mask;
		logic [MaskW-1:0] down_mask;
		logic [TgtW-1:0]  target_cores;
	} cchp_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cchp_req_if.sv =====
// Request channel: valid/ready handshake with the tick/suspend/resume payload.
// Depends on cchp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cchp_req_if
	import cchp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ReqW-1:0]     req_type;
	logic [LoadW-1:0]    load_sample;
	logic [MaskW-1:0]    online_mask;

	modport source (output valid, req_type, load_sample, online_mask, input ready);
	modport sink   (input valid, req_type, load_sample, online_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cchp_res_if.sv =====
// Result channel: valid/ready handshake with the up/down request masks.
// Depends on cchp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cchp_res_if
	import cchp_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [MaskW-1:0] up_mask;
	logic [MaskW-1:0] down_mask;
	logic [TgtW-1:0]  target_cores;

	modport source (output valid, up_mask, down_mask, target_cores, input ready);
	modport sink   (input valid, up_mask, down_mask, target_cores, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/core_count_hotplug_policy.sv =====
// Core-count hotplug policy: decides which of four cores to bring online or offline.
// Usage:
//   req  : sink channel, one beat per event (0 sample tick, 1 suspend, 2 resume)
//          with a load sample (11 fraction bits) and the current online-core mask.
//   res  : source channel, exactly one beat per request beat, in order, carrying
//          up_mask, down_mask and the computed target core count.
//   cfg  : write port for enable (index 0) and eco_mode (index 1); write only
//          while no request is in flight.
// Timing: a request accepted into the input register is evaluated there and its
//   result is registered in the result register, which drives res.
// Throughput: one request per cycle unless res stalls; the policy state (last target,
//   persistence count, suspend flag) is read and rewritten in the single evaluation
//   stage, so each beat sees the state its predecessor left.
// Reset: enable=1, eco_mode=0, state cleared, both stages empty.
// Stall: while res is not taken the result register holds; one further request
//   waits in the input register, after which req.ready drops.
// Depends on cchp_pkg, cchp_req_if, cchp_res_if, cchp_cfg_regs, cchp_eval.
`timescale 1ns / 1ps
`default_nettype none

module core_count_hotplug_policy
	import cchp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	cchp_req_if.sink                 req,
	cchp_res_if.source               res
);

	cchp_cfg_t   cfg;
	cchp_state_t state_q;
	cchp_state_t state_nxt;
	cchp_req_t   req_s1;
	logic        valid_s1;
	cchp_res_t   res_comb;
	cchp_res_t   res_s2;
	logic        valid_s2;
	logic        s2_free;
	logic        s1_adv;

	cchp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cchp_eval u_eval (
		.cfg       (cfg),
		.state     (state_q),
		.req       (req_s1),
		.state_nxt (state_nxt),
		.res       (res_comb)
	);

	// Handshake control
	assign s2_free   = !valid_s2 || res.ready;
	assign s1_adv    = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;

	// Input stage: take a beat whenever the stage is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.req_type    <= req.req_type;
			req_s1.load_sample <= req.load_sample;
			req_s1.online_mask <= req.online_mask;
		end
	end

	// Result stage: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			res_s2 <= res_comb;
	end

	// Policy state advances as each beat leaves the evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	assign res.valid        = valid_s2;
	assign res.up_mask      = res_s2.up_mask;
	assign res.down_mask    = res_s2.down_mask;
	assign res.target_cores = res_s2.target_cores;

endmodule

`default_nettype wire

// ===== rtl/core/cchp_cfg_regs.sv =====
// Configuration registers: enable and eco_mode, written through a plain write port.
// Depends on cchp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cchp_cfg_regs
	import cchp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	output cchp_cfg_t                cfg
);

	cchp_cfg_t cfg_q;

	// Capture a write to the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= 1'b1;
			cfg_q.eco_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgEnable: cfg_q.enable   <= cfg_wdata[0];
				CfgEco:    cfg_q.eco_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/cchp_eval.sv =====
// Policy evaluation: picks the target core count and builds the up/down masks
// and the next policy state for one request. Purely combinational; depends on cchp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cchp_eval
	import cchp_pkg::*;
(
	input  wire cchp_cfg_t   cfg,
	input  wire cchp_state_t state,
	input  wire cchp_req_t   req,
	output cchp_state_t      state_nxt,
	output cchp_res_t        res
);

	logic [CmpW-1:0]       load_ext;
	logic [FullLevels-1:0] full_hit;
	logic [ThrW-1:0]       thr;
	logic                  eco_hit;
	logic [TgtW-1:0]       target;
	logic [2:0]            cnt;
	logic [PersistW-1:0]   persist_dec;
	logic [MaskW-1:0]      up;
	logic [MaskW-1:0]      down;

	// Compare the load against every threshold in parallel
	always_comb begin
		load_ext = CmpW'(req.load_sample);
		for (int i = 0; i < FullLevels; i++) begin
			thr = FullThr[i];
			if (state.last_target <= TgtW'(i + 1))
				thr = FullThr[i] + FullHyst;
			full_hit[i] = load_ext <= (CmpW'(thr) << FullShift);
		end
		thr = EcoThr;
		if (state.last_target <= TgtW'(1))
			thr = EcoThr + EcoHyst;
		eco_hit = load_ext <= (CmpW'(thr) << EcoShift);
	end

	// Lowest matching level wins
	always_comb begin
		if (cfg.eco_mode) begin
			target = eco_hit ? TgtW'(1) : TgtW'(2);
		end else begin
			priority if (full_hit[0]) target = TgtW'(1);
			else if (full_hit[1])     target = TgtW'(2);
			else if (full_hit[2])     target = TgtW'(3);
			else                      target = TgtW'(4);
		end
	end

	// Build masks and next state
	always_comb begin
		cnt         = 3'($countones(req.online_mask));
		persist_dec = (state.persist_left != '0) ? state.persist_left - 1'b1
		                                         : state.persist_left;
		up          = '0;
		down        = '0;
		state_nxt   = state;
		res.target_cores = '0;

		unique case (req.req_type)
			ReqTick: begin
				if (cfg.enable) begin
					res.target_cores       = target;
					state_nxt.last_target  = target;
					if (!state.is_suspended) begin
						unique case (target)
							TgtW'(1): begin
								state_nxt.persist_left = persist_dec;
								if (cnt == 3'd2 && persist_dec == '0)
									down[1] = 1'b1;
								if (cfg.eco_mode)
									down[3:2] = 2'b11;
							end
							TgtW'(2): begin
								state_nxt.persist_left = PersistDual;
								if (cnt == 3'd1)
									up[1] = 1'b1;
								else
									down[3:2] = 2'b11;
							end
							TgtW'(3): begin
								state_nxt.persist_left = PersistTri;
								if (cnt == 3'd2)
									up[2] = 1'b1;
								else
									down[3] = 1'b1;
							end
							default: begin
								state_nxt.persist_left = PersistQuad;
								if (cnt == 3'd3)
									up[3] = 1'b1;
							end
						endcase
					end
				end
			end
			ReqSuspend: begin
				state_nxt.is_suspended = 1'b1;
				down = 4'b1110;
			end
			ReqResume: begin
				state_nxt.persist_left = PersistDual;
				state_nxt.is_suspended = 1'b0;
				up = cfg.eco_mode ? 4'b0010 : 4'b1110;
			end
			default: ;
		endcase

		// Drop requests that would not change a core
		res.up_mask   = up & ~req.online_mask;
		res.down_mask = down & req.online_mask;
	end

endmodule

`default_nettype wire

// ===== rtl/core/cchp_checker.sv =====
// Port-level checks for the hotplug policy result channel, bound to the top level.
// Depends on cchp_pkg and core_count_hotplug_policy.
`timescale 1ns / 1ps
`default_nettype none

module cchp_checker
	import cchp_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic [MaskW-1:0] up_mask,
	input wire logic [MaskW-1:0] down_mask,
	input wire logic [TgtW-1:0]  target_cores
);

	// Stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(up_mask) && $stable(down_mask)
			&& $stable(target_cores))
		else $error("result changed while stalled");

	// A core is never asked to go both ways
	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (up_mask & down_mask) == '0)
		else $error("up and down masks overlap");

	// Core 0 stays online and is never switched
	a_core0_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !up_mask[0] && !down_mask[0])
		else $error("request touches core 0");

	// Target never exceeds the cluster size
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> target_cores <= TgtW'(4))
		else $error("target out of range");

endmodule

bind core_count_hotplug_policy cchp_checker u_cchp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.up_mask      (res.up_mask),
	.down_mask    (res.down_mask),
	.target_cores (res.target_cores)
);

`default_nettype wire
